>>> design/dwrv_pkg.sv
// shared types and constants for the diffuse wall reflection velocity core
// no dependencies
package dwrv_pkg;

    localparam int UNIFORM_BITS  = 24;
    localparam int COUNT_BITS    = 32;
    localparam int SCALE_BITS    = 24;
    localparam int LOG_FRAC_BITS = 24;
    localparam int LOG_W         = 30;
    localparam int RAD_W         = 55;
    localparam int ROOT_W        = 28;
    localparam int SQ_W          = 56;
    localparam int VN_W          = 44;
    localparam int TV_W          = 46;
    localparam int ACC_W         = 64;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 24'd65536;
    localparam logic [30:0]           TWO_LN2_Q30 = 31'd1488522236;
    localparam logic                  REG_SCALE   = 1'b0;

    typedef struct packed {
        logic [UNIFORM_BITS-1:0] uniform_sample;
        logic signed [15:0]      gauss_first;
        logic signed [15:0]      gauss_second;
        logic signed [15:0]      normal_x;
        logic signed [15:0]      normal_y;
        logic signed [15:0]      normal_z;
        logic signed [15:0]      tan_a_x;
        logic signed [15:0]      tan_a_y;
        logic signed [15:0]      tan_a_z;
        logic signed [15:0]      tan_b_x;
        logic signed [15:0]      tan_b_y;
        logic signed [15:0]      tan_b_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [31:0]        collision_count;
    } out_item_t;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_NORM = 10'b0000000010,
        S_LOG  = 10'b0000000100,
        S_RAD  = 10'b0000001000,
        S_SQRT = 10'b0000010000,
        S_VN   = 10'b0000100000,
        S_TA   = 10'b0001000000,
        S_TB   = 10'b0010000000,
        S_MAC  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } state_t;

endpackage

>>> design/dwrv_front.sv
// front end: accepts items, maps a zero uniform draw to one lsb, queues them
// depends on dwrv_pkg
module dwrv_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dwrv_pkg::in_item_t s_item,
    output logic               q_valid,
    input  logic               q_ready,
    output dwrv_pkg::in_item_t q_item
);

    dwrv_pkg::in_item_t mem_reg [dwrv_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    dwrv_pkg::in_item_t fixed;
    logic push, pop;

    always_comb begin
        fixed = s_item;
        if (s_item.uniform_sample == '0) begin
            fixed.uniform_sample = dwrv_pkg::UNIFORM_BITS'(1);
        end
    end

    assign s_ready = count_reg != 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= fixed;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> design/dwrv_back.sv
// back end: log, square root, scaling and frame rotation on one sequencer
// depends on dwrv_pkg
module dwrv_back #(
    parameter int COUNT_BITS = dwrv_pkg::COUNT_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [dwrv_pkg::SCALE_BITS-1:0]     scale,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  dwrv_pkg::in_item_t                  q_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dwrv_pkg::out_item_t                 m_item
);

    dwrv_pkg::state_t state_reg, state_next;
    dwrv_pkg::in_item_t item_reg, item_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] norm_reg, norm_next;
    logic [4:0]  lz_reg, lz_next;
    logic [dwrv_pkg::LOG_FRAC_BITS-1:0] frac_reg, frac_next;
    logic [dwrv_pkg::RAD_W-1:0] rad_reg, rad_next;
    logic [dwrv_pkg::SQ_W-1:0]  x_reg, x_next, res_reg, res_next, bit_reg, bit_next;
    logic [dwrv_pkg::VN_W-1:0]  vn_reg, vn_next;
    logic signed [dwrv_pkg::TV_W-1:0] ta_reg, ta_next, tb_reg, tb_next;
    logic signed [dwrv_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [1:0] axis_reg, axis_next, term_reg, term_next;
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] vel_new;
    logic [COUNT_BITS-1:0] tally_reg, tally_next;
    dwrv_pkg::out_item_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic vel_we;

    logic [5:0]  shamt;
    logic [63:0] sq;
    logic [32:0] sq_sh;
    logic [5:0]  ip;
    logic [dwrv_pkg::LOG_W-1:0] l2;
    logic [60:0] rad_prod;
    logic [dwrv_pkg::SQ_W-1:0]  trial;
    logic [51:0] vn_prod;
    logic signed [40:0] t_prod;
    logic signed [dwrv_pkg::TV_W-1:0] op;
    logic signed [15:0] coef;
    logic signed [61:0] mac_prod;
    logic signed [dwrv_pkg::ACC_W-1:0] sum_r;
    logic signed [33:0] q;
    logic load_out;

    assign q_ready  = state_reg == dwrv_pkg::S_IDLE;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_reg;
    assign load_out = (state_reg == dwrv_pkg::S_DONE) && (!out_valid_reg || m_ready);

    always_comb begin
        shamt    = 6'd16 >> cnt_reg;
        sq       = {32'b0, norm_reg} * {32'b0, norm_reg};
        sq_sh    = sq[63:31];
        ip       = 6'(dwrv_pkg::UNIFORM_BITS) - 6'd31 + {1'b0, lz_reg};
        l2       = {ip, {dwrv_pkg::LOG_FRAC_BITS{1'b0}}} - dwrv_pkg::LOG_W'(frac_reg);
        rad_prod = 61'(l2) * 61'(dwrv_pkg::TWO_LN2_Q30);
        trial    = res_reg + bit_reg;
        vn_prod  = 52'(scale) * 52'(res_reg[dwrv_pkg::ROOT_W-1:0]);
        t_prod   = $signed({1'b0, scale}) *
                   ((state_reg == dwrv_pkg::S_TA) ? item_reg.gauss_first : item_reg.gauss_second);
        case (term_reg)
            2'd0:    op = $signed({2'b0, vn_reg});
            2'd1:    op = ta_reg;
            default: op = tb_reg;
        endcase
        case ({axis_reg, term_reg})
            4'b0000: coef = item_reg.normal_x;
            4'b0001: coef = item_reg.tan_a_x;
            4'b0010: coef = item_reg.tan_b_x;
            4'b0100: coef = item_reg.normal_y;
            4'b0101: coef = item_reg.tan_a_y;
            4'b0110: coef = item_reg.tan_b_y;
            4'b1000: coef = item_reg.normal_z;
            4'b1001: coef = item_reg.tan_a_z;
            default: coef = item_reg.tan_b_z;
        endcase
        mac_prod = op * coef;
        sum_r    = acc_reg + dwrv_pkg::ACC_W'(mac_prod) + dwrv_pkg::ACC_W'(64'sd1 <<< 29);
        q        = 34'(sum_r >>> 30);
        if (q > 34'sd2147483647) vel_new = 32'sh7fffffff;
        else if (q < -34'sd2147483648) vel_new = 32'sh80000000;
        else vel_new = q[31:0];
    end

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        norm_next      = norm_reg;
        lz_next        = lz_reg;
        frac_next      = frac_reg;
        rad_next       = rad_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        vn_next        = vn_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        acc_next       = acc_reg;
        axis_next      = axis_reg;
        term_next      = term_reg;
        vel_we         = 1'b0;
        tally_next     = tally_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            dwrv_pkg::S_IDLE: begin
                if (q_valid) begin
                    item_next  = q_item;
                    norm_next  = 32'(q_item.uniform_sample);
                    lz_next    = 5'd0;
                    cnt_next   = 5'd0;
                    state_next = dwrv_pkg::S_NORM;
                end
            end
            dwrv_pkg::S_NORM: begin
                if ((norm_reg >> (6'd32 - shamt)) == 32'd0) begin
                    norm_next = norm_reg << shamt;
                    lz_next   = lz_reg + shamt[4:0];
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd4) begin
                    cnt_next   = 5'd0;
                    frac_next  = '0;
                    state_next = dwrv_pkg::S_LOG;
                end
            end
            dwrv_pkg::S_LOG: begin
                frac_next = {frac_reg[dwrv_pkg::LOG_FRAC_BITS-2:0], sq_sh[32]};
                norm_next = sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'(dwrv_pkg::LOG_FRAC_BITS - 1)) begin
                    state_next = dwrv_pkg::S_RAD;
                end
            end
            dwrv_pkg::S_RAD: begin
                rad_next   = rad_prod[60:6];
                state_next = dwrv_pkg::S_SQRT;
                cnt_next   = 5'd0;
                x_next     = {1'b0, rad_prod[60:6]};
                res_next   = '0;
                bit_next   = dwrv_pkg::SQ_W'(1) << (dwrv_pkg::SQ_W - 2);
            end
            dwrv_pkg::S_SQRT: begin
                if (x_reg >= trial) begin
                    x_next   = x_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(dwrv_pkg::ROOT_W - 1)) begin
                    state_next = dwrv_pkg::S_VN;
                end
            end
            dwrv_pkg::S_VN: begin
                vn_next    = vn_prod[51:8];
                state_next = dwrv_pkg::S_TA;
            end
            dwrv_pkg::S_TA: begin
                ta_next    = dwrv_pkg::TV_W'(t_prod) <<< 4;
                state_next = dwrv_pkg::S_TB;
            end
            dwrv_pkg::S_TB: begin
                tb_next    = dwrv_pkg::TV_W'(t_prod) <<< 4;
                acc_next   = '0;
                axis_next  = 2'd0;
                term_next  = 2'd0;
                state_next = dwrv_pkg::S_MAC;
            end
            dwrv_pkg::S_MAC: begin
                if (term_reg == 2'd2) begin
                    vel_we    = 1'b1;
                    acc_next  = '0;
                    term_next = 2'd0;
                    axis_next = axis_reg + 2'd1;
                    if (axis_reg == 2'd2) state_next = dwrv_pkg::S_DONE;
                end else begin
                    acc_next  = acc_reg + dwrv_pkg::ACC_W'(mac_prod);
                    term_next = term_reg + 2'd1;
                end
            end
            dwrv_pkg::S_DONE: begin
                if (load_out) begin
                    tally_next                  = tally_reg + COUNT_BITS'(1);
                    out_next.vel_x              = vel_reg[0];
                    out_next.vel_y              = vel_reg[1];
                    out_next.vel_z              = vel_reg[2];
                    out_next.collision_count    = 32'(tally_reg + COUNT_BITS'(1));
                    out_valid_next              = 1'b1;
                    state_next                  = dwrv_pkg::S_IDLE;
                end
            end
            default: state_next = dwrv_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        cnt_reg  <= cnt_next;
        norm_reg <= norm_next;
        lz_reg   <= lz_next;
        frac_reg <= frac_next;
        rad_reg  <= rad_next;
        x_reg    <= x_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        vn_reg   <= vn_next;
        ta_reg   <= ta_next;
        tb_reg   <= tb_next;
        acc_reg  <= acc_next;
        axis_reg <= axis_next;
        term_reg <= term_next;
        out_reg  <= out_next;
        if (vel_we) vel_reg[axis_reg] <= vel_new;
        if (!aresetn) begin
            state_reg     <= dwrv_pkg::S_IDLE;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_log_normalized: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dwrv_pkg::S_LOG |-> norm_reg[31])
        else $error("log mantissa not normalized");

    a_result_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> out_valid_reg && state_reg == dwrv_pkg::S_IDLE)
        else $error("result not loaded");

    a_tally_step: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> tally_reg == $past(tally_reg) + COUNT_BITS'(1))
        else $error("collision tally did not advance");

    a_tally_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !load_out |=> $stable(tally_reg))
        else $error("collision tally changed without a result");

endmodule

>>> design/diffuse_wall_reflection_velocity_core.sv
// sequence per item: dispatch, 5 normalize steps, 24 log steps, scale, 28 square root
// steps, 3 multiplies, 9 rotation multiply-accumulates, load into the output register
// the shared log/square-root sequencer takes no new item until the previous result is loaded
// a two-entry queue and an output register let input and output stall on their own
// reset: synchronous active-low aresetn clears the queue, sequencer, tally; scale -> 1.0
// depends on dwrv_pkg, dwrv_front, dwrv_back
module diffuse_wall_reflection_velocity_core #(
    parameter int COUNT_BITS = dwrv_pkg::COUNT_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dwrv_pkg::in_item_t            s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dwrv_pkg::out_item_t           m_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dwrv_pkg::ADDR_W-1:0]   paddr,
    input  logic [dwrv_pkg::DATA_W-1:0]   pwdata,
    output logic [dwrv_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [dwrv_pkg::SCALE_BITS-1:0] scale_reg;
    logic q_valid, q_ready;
    dwrv_pkg::in_item_t q_item;
    logic sel_scale;

    assign pready    = 1'b1;
    assign sel_scale = paddr[dwrv_pkg::ADDR_W-1] == dwrv_pkg::REG_SCALE;
    assign prdata    = sel_scale ? dwrv_pkg::DATA_W'(scale_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= dwrv_pkg::SCALE_RESET;
        end else if (psel && penable && pwrite && sel_scale) begin
            scale_reg <= pwdata[dwrv_pkg::SCALE_BITS-1:0];
        end
    end

    dwrv_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    dwrv_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .scale   (scale_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
